// ===== design/drbs_pkg.sv =====
package drbs_pkg;

	typedef struct packed {
		logic [15:0] row;
		logic [1:0]  kind;
		logic [2:0]  thread;
		logic        marked;
		logic [7:0]  id;
	} entry_t;

	localparam logic OP_ENQUEUE  = 1'b0;
	localparam logic OP_SCHEDULE = 1'b1;

	localparam logic [2:0] ST_ENQUEUED = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_GRANTED  = 3'd2;
	localparam logic [2:0] ST_NONE     = 3'd3;
	localparam logic [2:0] ST_BLOCKED  = 3'd4;

	localparam logic [1:0] RS_HIT      = 2'd0;
	localparam logic [1:0] RS_CONFLICT = 2'd1;
	localparam logic [1:0] RS_CLOSED   = 2'd2;

	localparam logic [2:0] RULE_HIT      = 3'd0;
	localparam logic [2:0] RULE_READS    = 3'd1;
	localparam logic [2:0] RULE_RANKED   = 3'd2;
	localparam logic [2:0] RULE_OLDEST   = 3'd3;
	localparam logic [2:0] RULE_UNMARKED = 3'd4;

	localparam logic [1:0] POL_FCFS   = 2'd0;
	localparam logic [1:0] POL_FRFCFS = 2'd1;
	localparam logic [1:0] POL_PARBS  = 2'd2;

	localparam logic [1:0] KIND_OTHER = 2'd3;

	localparam logic REG_POLICY     = 1'b0;
	localparam logic REG_STREAK_CAP = 1'b1;

	localparam logic [1:0] POLICY_RESET     = POL_FRFCFS;
	localparam logic [7:0] STREAK_CAP_RESET = 8'd8;

endpackage

// ===== design/dram_bank_request_scheduler.sv =====
// Channel   Direction  Handshake               Contents
// in        input      in_valid / in_ready     operation, bank, request fields, downstream_ready
// out       output     out_valid / out_ready   status, granted request, row state, rule, tag
// cfg       input      cfg_write               cfg_index selects the register, cfg_data
//
// A schedule scans every request in the bank queue and, when a request is granted, moves each later
// request up by one place; under PAR-BS the thread ranking first walks every stored request of all
// banks and then compares the threads.
// Each request read goes through the single read port of the request memory.
// Reset clears queue counts, open rows and counters; no clearing pass is needed.
// A finished result waits in the output register while the next transaction is accepted.
module dram_bank_request_scheduler #(
	parameter int NUM_BANKS      = 8,
	parameter int QUEUE_DEPTH    = 16,
	parameter int NUM_THREADS    = 8,
	parameter int RESPONSE_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [2:0]  bank,
	input  logic [15:0] row,
	input  logic [1:0]  cmd_kind,
	input  logic [2:0]  thread,
	input  logic        marked,
	input  logic [7:0]  request_id,
	input  logic        downstream_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  granted_bank,
	output logic [15:0] granted_row,
	output logic [1:0]  granted_kind,
	output logic [2:0]  granted_thread,
	output logic [7:0]  granted_id,
	output logic [1:0]  row_state,
	output logic [2:0]  rule_used,
	output logic [4:0]  response_tag,
	output logic [7:0]  bypass_count,
	output logic [3:0]  granted_slot,
	output logic        queue_full
);
	import drbs_pkg::*;

	localparam int BW   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int SW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int AW   = BW + SW;
	localparam int TW   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
	localparam int MXW  = $clog2(QUEUE_DEPTH + 2);
	localparam int TOTW = $clog2(NUM_BANKS * QUEUE_DEPTH + 2);
	localparam int TGW  = (RESPONSE_SLOTS > 0) ? $clog2(2 * RESPONSE_SLOTS) : 1;
	localparam int EW   = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_WALK, S_RANK, S_SCAN, S_DECIDE,
		S_FETCH, S_FDATA, S_SHRD, S_SHWR, S_DONE
	} state_t;

	state_t state_q;

	logic        op_q;
	logic [2:0]  bank_q;
	entry_t      in_ent_q;
	logic        dready_q;
	logic [BW-1:0] bidx;

	logic [CW-1:0]  qcount_q   [NUM_BANKS];
	logic [15:0]    open_row_q [NUM_BANKS];
	logic           row_open_q [NUM_BANKS];
	logic [7:0]     bypass_q   [NUM_BANKS];
	logic [7:0]     streak_q;
	logic [TGW-1:0] tag_q;
	logic [1:0]     policy_q;
	logic [7:0]     cap_q;

	logic [BW-1:0]   wb_q;
	logic [CW-1:0]   ws_q;
	logic [MXW-1:0]  load_q [NUM_THREADS];
	logic [MXW-1:0]  mx_q   [NUM_THREADS];
	logic [TOTW-1:0] tot_q  [NUM_THREADS];
	logic [BW-1:0]   lastbank_q;
	logic            first_q;

	logic [TW-1:0]   rt_q;
	logic [TW-1:0]   best_q;
	logic [MXW-1:0]  bmx_q;
	logic [TOTW-1:0] btot_q;

	logic [CW-1:0] sc_q;
	logic          hit_f_q, dem_f_q, rank_f_q, elig_f_q;
	logic [SW-1:0] hit_s_q, dem_s_q, rank_s_q, elig_s_q;

	logic          rvalid_s1;
	logic [BW-1:0] rbank_s1;
	logic [SW-1:0] rslot_s1;

	logic [SW-1:0] sel_slot_q;
	logic [2:0]    sel_rule_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] sh_q;

	logic [2:0]  res_status_q, res_bank_q, res_thread_q, res_rule_q;
	logic [15:0] res_row_q;
	logic [1:0]  res_kind_q, res_rstate_q;
	logic [7:0]  res_id_q, res_bypass_q;
	logic [4:0]  res_tag_q;
	logic [3:0]  res_slot_q;
	logic        res_qfull_q;

	logic          out_valid_q;
	logic [2:0]    o_status_q, o_bank_q, o_thread_q, o_rule_q;
	logic [15:0]   o_row_q;
	logic [1:0]    o_kind_q, o_rstate_q;
	logic [7:0]    o_id_q, o_bypass_q;
	logic [4:0]    o_tag_q;
	logic [3:0]    o_slot_q;
	logic          o_qfull_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	entry_t        rd_ent;

	logic walk_issue, scan_issue, accept, bad_bank, pb, newbank, better, out_load;
	logic [MXW-1:0]  new_load [NUM_THREADS];
	logic [MXW-1:0]  eff_mx;
	logic [TOTW-1:0] eff_tot;
	logic scan_elig, scan_hit;

	assign bidx       = BW'(bank_q);
	assign rd_ent     = entry_t'(mem_rdata);
	assign accept     = in_valid && in_ready;
	assign in_ready   = (state_q == S_IDLE);
	assign bad_bank   = (32'(bank_q) >= NUM_BANKS);
	assign pb         = (policy_q == POL_PARBS);
	assign walk_issue = (state_q == S_WALK) && (ws_q < qcount_q[wb_q]);
	assign scan_issue = (state_q == S_SCAN) && (sc_q < qcount_q[bidx]);
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (state_q)
			S_WALK:  mem_raddr = {wb_q, ws_q[SW-1:0]};
			S_SCAN:  mem_raddr = {bidx, sc_q[SW-1:0]};
			S_FETCH: mem_raddr = {bidx, sel_slot_q};
			S_SHRD:  mem_raddr = {bidx, SW'(sh_q + CW'(1))};
			default: mem_raddr = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {bidx, qcount_q[bidx][SW-1:0]};
		mem_wdata = in_ent_q;
		if (state_q == S_START && op_q == OP_ENQUEUE && !bad_bank &&
		    qcount_q[bidx] != CW'(QUEUE_DEPTH)) begin
			mem_we = 1'b1;
		end else if (state_q == S_SHWR) begin
			mem_we    = 1'b1;
			mem_waddr = {bidx, sh_q[SW-1:0]};
			mem_wdata = mem_rdata;
		end
	end

	drbs_ram #(
		.WIDTH(EW),
		.DEPTH(2 ** AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Per-thread load for the bank being walked restarts when the arriving read moves to a
	// new bank, so the maximum over time equals the largest per-bank load.
	assign newbank = first_q || (rbank_s1 != lastbank_q);
	always_comb begin
		for (int t = 0; t < NUM_THREADS; t++) begin
			new_load[t] = (newbank ? '0 : load_q[t]) +
				MXW'(rd_ent.marked && ({2'b00, rd_ent.thread} == 5'(t)));
		end
	end

	always_comb begin
		eff_mx  = (mx_q[rt_q] == '0) ? MXW'(QUEUE_DEPTH + 1) : mx_q[rt_q];
		eff_tot = (tot_q[rt_q] == '0) ? TOTW'(QUEUE_DEPTH + 1) : tot_q[rt_q];
		better  = (rt_q == '0) || (eff_mx < bmx_q) || (eff_mx == bmx_q && eff_tot < btot_q);
	end

	assign scan_elig = !pb || rd_ent.marked;
	assign scan_hit  = scan_elig && row_open_q[bidx] && (rd_ent.row == open_row_q[bidx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= POLICY_RESET;
			cap_q       <= STREAK_CAP_RESET;
			streak_q    <= '0;
			tag_q       <= '0;
			out_valid_q <= 1'b0;
			rvalid_s1   <= 1'b0;
			for (int b = 0; b < NUM_BANKS; b++) begin
				qcount_q[b]   <= '0;
				open_row_q[b] <= '0;
				row_open_q[b] <= 1'b0;
				bypass_q[b]   <= '0;
			end
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_POLICY:     policy_q <= cfg_data[1:0];
					REG_STREAK_CAP: cap_q    <= cfg_data;
					default: ;
				endcase
			end

			rvalid_s1 <= walk_issue || scan_issue;
			rbank_s1  <= (state_q == S_WALK) ? wb_q : bidx;
			rslot_s1  <= (state_q == S_WALK) ? ws_q[SW-1:0] : sc_q[SW-1:0];

			if (out_load) begin
				out_valid_q <= 1'b1;
				o_status_q  <= res_status_q;
				o_bank_q    <= res_bank_q;
				o_row_q     <= res_row_q;
				o_kind_q    <= res_kind_q;
				o_thread_q  <= res_thread_q;
				o_id_q      <= res_id_q;
				o_rstate_q  <= res_rstate_q;
				o_rule_q    <= res_rule_q;
				o_tag_q     <= res_tag_q;
				o_bypass_q  <= res_bypass_q;
				o_slot_q    <= res_slot_q;
				o_qfull_q   <= res_qfull_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q            <= operation;
						bank_q          <= bank;
						in_ent_q.row    <= row;
						in_ent_q.kind   <= cmd_kind;
						in_ent_q.thread <= thread;
						in_ent_q.marked <= marked;
						in_ent_q.id     <= request_id;
						dready_q        <= downstream_ready;
						res_status_q    <= ST_NONE;
						res_bank_q      <= '0;
						res_row_q       <= '0;
						res_kind_q      <= '0;
						res_thread_q    <= '0;
						res_id_q        <= '0;
						res_rstate_q    <= '0;
						res_rule_q      <= '0;
						res_tag_q       <= '0;
						res_bypass_q    <= '0;
						res_slot_q      <= '0;
						res_qfull_q     <= 1'b0;
						wb_q            <= '0;
						ws_q            <= '0;
						first_q         <= 1'b1;
						rt_q            <= '0;
						sc_q            <= '0;
						hit_f_q         <= 1'b0;
						dem_f_q         <= 1'b0;
						rank_f_q        <= 1'b0;
						elig_f_q        <= 1'b0;
						for (int t = 0; t < NUM_THREADS; t++) begin
							load_q[t] <= '0;
							mx_q[t]   <= '0;
							tot_q[t]  <= '0;
						end
						state_q <= S_START;
					end
				end
				S_START: begin
					if (op_q == OP_ENQUEUE) begin
						if (bad_bank) begin
							res_status_q <= ST_FULL;
							res_qfull_q  <= 1'b1;
						end else if (qcount_q[bidx] == CW'(QUEUE_DEPTH)) begin
							res_status_q <= ST_FULL;
							res_bypass_q <= bypass_q[bidx];
							res_qfull_q  <= 1'b1;
						end else begin
							qcount_q[bidx] <= qcount_q[bidx] + CW'(1);
							res_status_q   <= ST_ENQUEUED;
							res_bypass_q   <= bypass_q[bidx];
							res_qfull_q    <= (qcount_q[bidx] + CW'(1) == CW'(QUEUE_DEPTH));
						end
						state_q <= S_DONE;
					end else if (bad_bank) begin
						state_q <= S_DONE;
					end else if (qcount_q[bidx] == '0) begin
						res_bypass_q <= bypass_q[bidx];
						state_q      <= S_DONE;
					end else begin
						state_q <= pb ? S_WALK : S_SCAN;
					end
				end
				S_WALK: begin
					if (rvalid_s1) begin
						first_q    <= 1'b0;
						lastbank_q <= rbank_s1;
						for (int t = 0; t < NUM_THREADS; t++) begin
							load_q[t] <= new_load[t];
							if (new_load[t] > mx_q[t]) begin
								mx_q[t] <= new_load[t];
							end
							if (rd_ent.marked && ({2'b00, rd_ent.thread} == 5'(t))) begin
								tot_q[t] <= tot_q[t] + TOTW'(1);
							end
						end
					end
					if (walk_issue) begin
						ws_q <= ws_q + CW'(1);
					end else begin
						ws_q <= '0;
						if (wb_q == BW'(NUM_BANKS - 1)) begin
							state_q <= S_RANK;
						end else begin
							wb_q <= wb_q + BW'(1);
						end
					end
				end
				S_RANK: begin
					if (better) begin
						best_q <= rt_q;
						bmx_q  <= eff_mx;
						btot_q <= eff_tot;
					end
					if (rt_q == TW'(NUM_THREADS - 1)) begin
						state_q <= S_SCAN;
					end else begin
						rt_q <= rt_q + TW'(1);
					end
				end
				S_SCAN: begin
					if (rvalid_s1) begin
						if (scan_hit && !hit_f_q) begin
							hit_f_q <= 1'b1;
							hit_s_q <= rslot_s1;
						end
						if (scan_elig && rd_ent.kind != KIND_OTHER && !dem_f_q) begin
							dem_f_q <= 1'b1;
							dem_s_q <= rslot_s1;
						end
						if (pb && rd_ent.marked && ({2'b00, rd_ent.thread} == 5'(best_q)) &&
						    !rank_f_q) begin
							rank_f_q <= 1'b1;
							rank_s_q <= rslot_s1;
						end
						if (scan_elig && !elig_f_q) begin
							elig_f_q <= 1'b1;
							elig_s_q <= rslot_s1;
						end
					end
					if (scan_issue) begin
						sc_q <= sc_q + CW'(1);
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					n_q <= qcount_q[bidx];
					priority if (policy_q == POL_FCFS) begin
						sel_slot_q <= '0;
						sel_rule_q <= RULE_OLDEST;
					end else if (hit_f_q) begin
						sel_slot_q <= hit_s_q;
						sel_rule_q <= RULE_HIT;
					end else if (streak_q < cap_q && dem_f_q) begin
						sel_slot_q <= dem_s_q;
						sel_rule_q <= RULE_READS;
					end else if (pb && rank_f_q) begin
						sel_slot_q <= rank_s_q;
						sel_rule_q <= RULE_RANKED;
					end else if (elig_f_q) begin
						sel_slot_q <= elig_s_q;
						sel_rule_q <= RULE_OLDEST;
					end else begin
						sel_slot_q <= '0;
						sel_rule_q <= RULE_UNMARKED;
					end
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					state_q <= S_FDATA;
				end
				S_FDATA: begin
					res_bank_q   <= bank_q;
					res_row_q    <= rd_ent.row;
					res_kind_q   <= rd_ent.kind;
					res_thread_q <= rd_ent.thread;
					res_id_q     <= rd_ent.id;
					res_rule_q   <= sel_rule_q;
					res_slot_q   <= 4'(sel_slot_q);
					if (!row_open_q[bidx]) begin
						res_rstate_q <= RS_CLOSED;
					end else if (rd_ent.row == open_row_q[bidx]) begin
						res_rstate_q <= RS_HIT;
					end else begin
						res_rstate_q <= RS_CONFLICT;
					end
					if (!dready_q) begin
						res_status_q <= ST_BLOCKED;
						res_bypass_q <= bypass_q[bidx];
						res_qfull_q  <= (n_q == CW'(QUEUE_DEPTH));
						state_q      <= S_DONE;
					end else begin
						res_status_q <= ST_GRANTED;
						res_qfull_q  <= 1'b0;
						if (sel_rule_q == RULE_HIT || sel_rule_q == RULE_READS ||
						    sel_rule_q == RULE_RANKED) begin
							if (sel_slot_q == '0) begin
								bypass_q[bidx] <= '0;
								res_bypass_q   <= '0;
							end else if (bypass_q[bidx] != 8'hFF) begin
								bypass_q[bidx] <= bypass_q[bidx] + 8'd1;
								res_bypass_q   <= bypass_q[bidx] + 8'd1;
							end else begin
								res_bypass_q <= bypass_q[bidx];
							end
						end else begin
							res_bypass_q <= bypass_q[bidx];
						end
						if (rd_ent.kind != KIND_OTHER) begin
							if (streak_q != 8'hFF) begin
								streak_q <= streak_q + 8'd1;
							end
							res_tag_q <= 5'(tag_q);
							tag_q     <= (tag_q == TGW'(2 * RESPONSE_SLOTS - 1)) ? '0
								: tag_q + TGW'(1);
						end else if (sel_rule_q != RULE_HIT) begin
							streak_q <= '0;
						end
						open_row_q[bidx] <= rd_ent.row;
						row_open_q[bidx] <= 1'b1;
						qcount_q[bidx]   <= n_q - CW'(1);
						sh_q             <= CW'(sel_slot_q);
						state_q <= (CW'(sel_slot_q) + CW'(1) < n_q) ? S_SHRD : S_DONE;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					// Each later request moves up by one place, head side first.
					sh_q    <= sh_q + CW'(1);
					state_q <= (sh_q + CW'(2) < n_q) ? S_SHRD : S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = o_status_q;
	assign granted_bank   = o_bank_q;
	assign granted_row    = o_row_q;
	assign granted_kind   = o_kind_q;
	assign granted_thread = o_thread_q;
	assign granted_id     = o_id_q;
	assign row_state      = o_rstate_q;
	assign rule_used      = o_rule_q;
	assign response_tag   = o_tag_q;
	assign bypass_count   = o_bypass_q;
	assign granted_slot   = o_slot_q;
	assign queue_full     = o_qfull_q;

endmodule

// ===== design/drbs_ram.sv =====
module drbs_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
